### rtl/hkrd_pkg.sv
package hkrd_pkg;

  localparam int MAP_WORDS = 8;
  localparam int WORD_BITS = 32;
  localparam int WORD_IDX_W = 3;
  localparam int BIT_IDX_W = 5;
  localparam int SLOT_COUNT = 6;
  localparam int MOD_WORD = 7;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef logic [WORD_BITS-1:0] map_word_t;
  typedef map_word_t [MAP_WORDS-1:0] key_map_t;
  typedef logic [7:0] usage_t;

  typedef struct packed {
    key_map_t released;
    key_map_t pressed;
  } diff_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FLUSH
  } back_state_t;

endpackage

### rtl/hkrd_front.sv
module hkrd_front
  import hkrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  modifier_bits,
  input  logic [7:0]  key_slot_a,
  input  logic [7:0]  key_slot_b,
  input  logic [7:0]  key_slot_c,
  input  logic [7:0]  key_slot_d,
  input  logic [7:0]  key_slot_e,
  input  logic [7:0]  key_slot_f,
  input  q_status_t   q_status,
  output logic        q_push,
  output diff_entry_t q_entry
);

  key_map_t prev_map;
  key_map_t cur_map;
  usage_t   slots [SLOT_COUNT];
  logic     live;

  assign slots[0] = key_slot_a;
  assign slots[1] = key_slot_b;
  assign slots[2] = key_slot_c;
  assign slots[3] = key_slot_d;
  assign slots[4] = key_slot_e;
  assign slots[5] = key_slot_f;

  always_comb begin
    cur_map = '0;
    cur_map[MOD_WORD] = {{(WORD_BITS-8){1'b0}}, modifier_bits};
    live = 1'b1;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slots[i] == 8'd0) begin
        live = 1'b0;
      end
      if (live) begin
        cur_map[slots[i][7:5]][slots[i][4:0]] = 1'b1;
      end
    end
  end

  assign full = q_status.full;
  assign q_push = push && !q_status.full;
  assign q_entry.released = prev_map & ~cur_map;
  assign q_entry.pressed = cur_map & ~prev_map;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_map <= '0;
    end else if (q_push) begin
      prev_map <= cur_map;
    end
  end

endmodule

### rtl/hkrd_queue.sv
module hkrd_queue
  import hkrd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr,
  input  diff_entry_t wr_data,
  input  logic        rd,
  output diff_entry_t rd_data,
  output q_status_t   status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  diff_entry_t     mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr;
  logic            do_rd;

  assign status.full = (count == FULL_CNT);
  assign status.empty = (count == '0);
  assign do_wr = wr && !status.full;
  assign do_rd = rd && !status.empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/hkrd_back.sv
module hkrd_back
  import hkrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  q_status_t   q_status,
  input  diff_entry_t q_data,
  output logic        q_pop,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  key_usage,
  output logic        is_press,
  output logic        last_event
);

  function automatic logic [BIT_IDX_W-1:0] lowest_bit(input map_word_t w);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = BIT_IDX_W'(i);
      end
    end
    return idx;
  endfunction

  localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(MAP_WORDS - 1);

  back_state_t            state;
  back_state_t            state_next;
  key_map_t               rel_map;
  key_map_t               prs_map;
  logic                   phase;
  logic [WORD_IDX_W-1:0]  widx;
  logic                   have_pend;
  usage_t                 pend_usage;
  logic                   pend_press;
  logic                   out_valid;

  map_word_t              cur_word;
  logic [BIT_IDX_W-1:0]   bidx;
  logic                   word_hit;
  logic                   out_free;
  logic                   load;
  logic                   take;
  logic                   advance;
  logic                   emit;
  logic                   emit_last;

  assign cur_word = phase ? prs_map[widx] : rel_map[widx];
  assign word_hit = (cur_word != '0);
  assign bidx = lowest_bit(cur_word);
  assign out_free = !out_valid || pop;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_status.empty) begin
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (!word_hit && phase && widx == LAST_WORD) begin
          state_next = BK_FLUSH;
        end
      end
      BK_FLUSH: begin
        if (!have_pend || out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    load = 1'b0;
    take = 1'b0;
    advance = 1'b0;
    emit = 1'b0;
    emit_last = 1'b0;
    unique case (state)
      BK_IDLE: begin
        load = !q_status.empty;
      end
      BK_SCAN: begin
        if (word_hit) begin
          take = !have_pend || out_free;
          emit = have_pend && out_free;
        end else begin
          advance = 1'b1;
        end
      end
      BK_FLUSH: begin
        emit = have_pend && out_free;
        emit_last = 1'b1;
      end
      default: ;
    endcase
  end

  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      have_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (take) begin
        have_pend <= 1'b1;
      end else if (emit) begin
        have_pend <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rel_map <= q_data.released;
      prs_map <= q_data.pressed;
      phase <= 1'b0;
      widx <= '0;
    end
    if (take) begin
      if (phase) begin
        prs_map[widx][bidx] <= 1'b0;
      end else begin
        rel_map[widx][bidx] <= 1'b0;
      end
      pend_usage <= {widx, bidx};
      pend_press <= phase;
    end
    if (advance) begin
      if (widx == LAST_WORD) begin
        widx <= '0;
        phase <= 1'b1;
      end else begin
        widx <= widx + 1'b1;
      end
    end
    if (emit) begin
      key_usage <= pend_usage;
      is_press <= pend_press;
      last_event <= emit_last;
    end
  end

  assign empty = !out_valid;

endmodule

### rtl/hid_keyboard_report_differ_unit.sv
// Channel  | Direction | Handshake    | Word
// report   | in        | push / full  | modifier_bits, key_slot_a .. key_slot_f
// event    | out       | empty / pop  | key_usage, is_press, last_event
//
// A report is accepted when push is high and full is low, and its released and
// pressed maps enter a short queue. The back end scans 8 map words per group,
// one word or one event per cycle while a held output word does not stall it.
// Reset clears the kept key map and the queue and empties the output word.
// full rises when the queue holds QUEUE_DEPTH reports; a held output word
// stalls only the event scan.
module hid_keyboard_report_differ_unit
  import hkrd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] modifier_bits,
  input  logic [7:0] key_slot_a,
  input  logic [7:0] key_slot_b,
  input  logic [7:0] key_slot_c,
  input  logic [7:0] key_slot_d,
  input  logic [7:0] key_slot_e,
  input  logic [7:0] key_slot_f,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] key_usage,
  output logic       is_press,
  output logic       last_event
);

  q_status_t   q_status;
  logic        q_push;
  logic        q_pop;
  diff_entry_t q_wr_data;
  diff_entry_t q_rd_data;

  hkrd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .modifier_bits (modifier_bits),
    .key_slot_a    (key_slot_a),
    .key_slot_b    (key_slot_b),
    .key_slot_c    (key_slot_c),
    .key_slot_d    (key_slot_d),
    .key_slot_e    (key_slot_e),
    .key_slot_f    (key_slot_f),
    .q_status      (q_status),
    .q_push        (q_push),
    .q_entry       (q_wr_data)
  );

  hkrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wr_data),
    .rd      (q_pop),
    .rd_data (q_rd_data),
    .status  (q_status)
  );

  hkrd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .q_data     (q_rd_data),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .key_usage  (key_usage),
    .is_press   (is_press),
    .last_event (last_event)
  );

endmodule

### rtl/hkrd_checker.sv
module hkrd_checker
  import hkrd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] key_usage,
  input logic       is_press,
  input logic       last_event
);

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(key_usage) && $stable(is_press)
                          && $stable(last_event)))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  a_reset_full: assert property (@(posedge clk) rst |=> !full)
    else $error("queue full after reset");

  a_full_needs_push: assert property (@(posedge clk) disable iff (rst)
    (!full && !push) |=> !full)
    else $error("queue filled without an accepted word");

endmodule

bind hid_keyboard_report_differ_unit hkrd_checker u_hkrd_checker (
  .clk        (clk),
  .rst        (rst),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .key_usage  (key_usage),
  .is_press   (is_press),
  .last_event (last_event)
);
